[rtl/core/vra_pkg.sv]
// Shared types and constants for the variant region annotator.
`timescale 1ns / 1ps
package vra_pkg;

    localparam int MAX_TRANSCRIPTS = 1024;
    localparam int MAX_REGIONS     = 8192;
    localparam int MAX_HITS        = 64;

    localparam int POS_W  = 32;
    localparam int TYPE_W = 3;
    localparam int TX_AW  = $clog2(MAX_TRANSCRIPTS);
    localparam int TX_CW  = $clog2(MAX_TRANSCRIPTS + 1);
    localparam int RG_AW  = $clog2(MAX_REGIONS);
    localparam int RG_CW  = $clog2(MAX_REGIONS + 1);
    localparam int HITS_W = $clog2(MAX_HITS + 1);

    localparam logic [1:0] CMD_CLEAR    = 2'd0;
    localparam logic [1:0] CMD_LOAD_TX  = 2'd1;
    localparam logic [1:0] CMD_LOAD_REG = 2'd2;
    localparam logic [1:0] CMD_QUERY    = 2'd3;

    localparam logic [TYPE_W-1:0] TYPE_OTHER = 3'd6;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_LOAD_TX,
        OP_LOAD_REG,
        OP_QUERY
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [POS_W-1:0]  span_start;
        logic [POS_W-1:0]  span_end;
        logic [TYPE_W-1:0] region_type;
        logic [POS_W-1:0]  position;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]  echo_position;
        logic [TX_AW-1:0]  hit_transcript;
        logic [TYPE_W-1:0] hit_type;
        logic [POS_W-1:0]  hit_start;
        logic [POS_W-1:0]  hit_end;
        logic              intergenic;
        logic              truncated;
        logic              last;
    } result_t;

endpackage

[rtl/core/vra_ifs.sv]
// Handshake interfaces for the command and result channels.
`timescale 1ns / 1ps
interface vra_in_if;
    import vra_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [POS_W-1:0]  span_start;
    logic [POS_W-1:0]  span_end;
    logic [TYPE_W-1:0] load_region_type;
    logic [POS_W-1:0]  query_position;

    modport source (output valid, command, span_start, span_end, load_region_type,
                    query_position, input ready);
    modport sink (input valid, command, span_start, span_end, load_region_type,
                  query_position, output ready);
endinterface

interface vra_out_if;
    import vra_pkg::*;
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  echo_position;
    logic [TX_AW-1:0]  hit_transcript;
    logic [TYPE_W-1:0] hit_type;
    logic [POS_W-1:0]  hit_start;
    logic [POS_W-1:0]  hit_end;
    logic              intergenic;
    logic              truncated;
    logic              last;

    modport source (output valid, echo_position, hit_transcript, hit_type, hit_start,
                    hit_end, intergenic, truncated, last, input ready);
    modport sink (input valid, echo_position, hit_transcript, hit_type, hit_start,
                  hit_end, intergenic, truncated, last, output ready);
endinterface

[rtl/core/variant_region_annotator.sv]
// Top level of the variant region annotator: command queue front end and sweep back end.
//
//   channel  direction  beat
//   req      in         command, span_start, span_end, load_region_type, query_position
//   rsp      out        echo_position, hit_transcript, hit_type, hit_start, hit_end,
//                       intergenic, truncated, last
//
// Clear and load beats are handled in the back end's idle state. A query's duration grows
// with T, the transcripts visited from the window base, and R, the regions scanned, since
// each step waits on the registered reads of the transcript and region RAMs.
// Reset clears counts and control state; table contents stay undefined until loaded.
// A two-entry queue lets req accept up to two beats while the back end is busy or rsp stalls.
`timescale 1ns / 1ps
module variant_region_annotator import vra_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    vra_in_if.sink     req,
    vra_out_if.source  rsp
);
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    vra_front u_front (
        .clk(clk), .rst_n(rst_n), .req(req),
        .q_valid(q_valid), .q_item(q_item), .q_ready(q_ready));

    vra_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_item(q_item), .q_ready(q_ready), .rsp(rsp));

    a_inter_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.intergenic |-> rsp.last && !rsp.truncated)
        else $error("intergenic beat not a lone final beat");

    a_inter_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.intergenic |-> rsp.hit_start == '0 && rsp.hit_end == '0
                                        && rsp.hit_transcript == '0 && rsp.hit_type == '0)
        else $error("intergenic beat carries region fields");

    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.truncated |-> rsp.last)
        else $error("truncated flag on a non-final beat");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready && !q_valid |=> !(q_item.op == OP_QUERY && !q_ready && !q_valid))
        else $error("back end left idle without a queued item");
endmodule

[rtl/core/vra_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module vra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[rtl/core/vra_front.sv]
// Front end: accept command beats, classify them and queue them for the back end.
`timescale 1ns / 1ps
module vra_front import vra_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    vra_in_if.sink req,
    output logic   q_valid,
    output item_t  q_item,
    input  logic   q_ready
);
    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    item_t      item_in;
    logic       push, pop;

    always_comb
    begin
        case (req.command)
            CMD_CLEAR:    item_in.op = OP_CLEAR;
            CMD_LOAD_TX:  item_in.op = OP_LOAD_TX;
            CMD_LOAD_REG: item_in.op = OP_LOAD_REG;
            default:      item_in.op = OP_QUERY;
        endcase
        item_in.span_start  = req.span_start;
        item_in.span_end    = req.span_end;
        item_in.region_type = (req.load_region_type > TYPE_OTHER) ? TYPE_OTHER
                                                                  : req.load_region_type;
        item_in.position    = req.query_position;
    end

    assign req.ready = (count_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != 2'd0);
    assign q_item    = entry_reg[rd_ptr_reg];
    assign pop       = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

[rtl/core/vra_back.sv]
// Back end: table loads and the overlap sweep that produces result beats.
`timescale 1ns / 1ps
module vra_back import vra_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  item_t      q_item,
    output logic       q_ready,
    vra_out_if.source  rsp
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_TX_CHECK,
        S_TX_EVAL,
        S_REG_ISSUE,
        S_REG_EVAL,
        S_FINISH
    } state_t;

    localparam int TXW = 2 * POS_W + RG_CW;
    localparam int RGW = 2 * POS_W + TYPE_W;

    typedef struct packed {
        logic [TX_AW-1:0]  tx;
        logic [TYPE_W-1:0] rtype;
        logic [POS_W-1:0]  rstart;
        logic [POS_W-1:0]  rend;
    } hit_t;

    state_t            state_reg, state_next;
    logic [TX_CW-1:0]  tx_count_reg, tx_count_next;
    logic [RG_CW-1:0]  rg_count_reg, rg_count_next;
    logic [TX_CW-1:0]  wbase_reg, wbase_next;
    logic [RG_CW-1:0]  cur_cnt_reg, cur_cnt_next;
    logic [TX_CW-1:0]  idx_reg, idx_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [RG_CW-1:0]  first_reg, first_next;
    logic [RG_CW-1:0]  cnt_reg, cnt_next;
    logic [RG_CW-1:0]  j_reg, j_next;
    logic [HITS_W-1:0] hits_reg, hits_next;
    logic              over_reg, over_next;
    logic              trunc_reg, trunc_next;
    logic              pend_valid_reg, pend_valid_next;
    hit_t              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic              tx_we, tx_re, cnt_we, cnt_re, rg_we, rg_re;
    logic [TX_AW-1:0]  tx_waddr, cnt_waddr;
    logic [TXW-1:0]    tx_wdata, tx_rdata;
    logic [RG_CW-1:0]  cnt_wdata, cnt_rdata;
    logic [RG_AW-1:0]  rg_waddr, rg_raddr;
    logic [RGW-1:0]    rg_wdata, rg_rdata;

    logic [POS_W-1:0]  tx_s, tx_e, rg_s, rg_e;
    logic [RG_CW-1:0]  tx_f;
    logic [TYPE_W-1:0] rg_t;
    logic [RG_CW:0]    rg_idx;
    logic              slot_free;

    vra_ram #(.WIDTH(TXW), .DEPTH(MAX_TRANSCRIPTS)) u_tx_ram (
        .clk(clk), .we(tx_we), .waddr(tx_waddr), .wdata(tx_wdata),
        .re(tx_re), .raddr(idx_reg[TX_AW-1:0]), .rdata(tx_rdata));

    vra_ram #(.WIDTH(RG_CW), .DEPTH(MAX_TRANSCRIPTS)) u_cnt_ram (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .re(cnt_re), .raddr(idx_reg[TX_AW-1:0]), .rdata(cnt_rdata));

    vra_ram #(.WIDTH(RGW), .DEPTH(MAX_REGIONS)) u_rg_ram (
        .clk(clk), .we(rg_we), .waddr(rg_waddr), .wdata(rg_wdata),
        .re(rg_re), .raddr(rg_raddr), .rdata(rg_rdata));

    assign {tx_s, tx_e, tx_f} = tx_rdata;
    assign {rg_s, rg_e, rg_t} = rg_rdata;
    assign rg_idx    = {1'b0, first_reg} + {1'b0, j_reg};
    assign rg_raddr  = rg_idx[RG_AW-1:0];
    assign slot_free = !out_valid_reg || rsp.ready;
    assign q_ready   = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        tx_count_next   = tx_count_reg;
        rg_count_next   = rg_count_reg;
        wbase_next      = wbase_reg;
        cur_cnt_next    = cur_cnt_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        first_next      = first_reg;
        cnt_next        = cnt_reg;
        j_next          = j_reg;
        hits_next       = hits_reg;
        over_next       = over_reg;
        trunc_next      = trunc_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_next        = out_reg;

        tx_we     = 1'b0;
        tx_re     = 1'b0;
        cnt_we    = 1'b0;
        cnt_re    = 1'b0;
        rg_we     = 1'b0;
        rg_re     = 1'b0;
        tx_waddr  = tx_count_reg[TX_AW-1:0];
        tx_wdata  = {q_item.span_start, q_item.span_end, rg_count_reg};
        cnt_waddr = tx_count_reg[TX_AW-1:0];
        cnt_wdata = '0;
        rg_waddr  = rg_count_reg[RG_AW-1:0];
        rg_wdata  = {q_item.span_start, q_item.span_end, q_item.region_type};

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.op)
                        OP_CLEAR:
                        begin
                            tx_count_next = '0;
                            rg_count_next = '0;
                            wbase_next    = '0;
                        end
                        OP_LOAD_TX:
                        begin
                            if (tx_count_reg != TX_CW'(MAX_TRANSCRIPTS))
                            begin
                                tx_we         = 1'b1;
                                cnt_we        = 1'b1;
                                cur_cnt_next  = '0;
                                tx_count_next = tx_count_reg + 1'b1;
                            end
                        end
                        OP_LOAD_REG:
                        begin
                            if (tx_count_reg != '0 && rg_count_reg != RG_CW'(MAX_REGIONS))
                            begin
                                rg_we         = 1'b1;
                                cnt_we        = 1'b1;
                                cnt_waddr     = TX_AW'(tx_count_reg - 1'b1);
                                cnt_wdata     = cur_cnt_reg + 1'b1;
                                cur_cnt_next  = cur_cnt_reg + 1'b1;
                                rg_count_next = rg_count_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            pos_next        = q_item.position;
                            idx_next        = wbase_reg;
                            hits_next       = '0;
                            over_next       = 1'b0;
                            trunc_next      = 1'b0;
                            pend_valid_next = 1'b0;
                            state_next      = S_TX_CHECK;
                        end
                    endcase
                end
            end
            S_TX_CHECK:
            begin
                if (idx_reg >= tx_count_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    tx_re      = 1'b1;
                    cnt_re     = 1'b1;
                    state_next = S_TX_EVAL;
                end
            end
            S_TX_EVAL:
            begin
                if (pos_reg < tx_s)
                begin
                    state_next = S_FINISH;
                end
                else if (pos_reg <= tx_e)
                begin
                    over_next  = 1'b1;
                    first_next = tx_f;
                    cnt_next   = cnt_rdata;
                    j_next     = '0;
                    state_next = S_REG_ISSUE;
                end
                else
                begin
                    if (idx_reg == wbase_reg)
                    begin
                        wbase_next = wbase_reg + 1'b1;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_TX_CHECK;
                end
            end
            S_REG_ISSUE:
            begin
                if (j_reg >= cnt_reg || rg_idx >= (RG_CW + 1)'(MAX_REGIONS))
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_TX_CHECK;
                end
                else
                begin
                    rg_re      = 1'b1;
                    state_next = S_REG_EVAL;
                end
            end
            S_REG_EVAL:
            begin
                if (pos_reg >= rg_s && pos_reg <= rg_e)
                begin
                    if (hits_reg == HITS_W'(MAX_HITS))
                    begin
                        trunc_next = 1'b1;
                        state_next = S_FINISH;
                    end
                    else if (!pend_valid_reg || slot_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = '{pos_reg, pend_reg.tx, pend_reg.rtype,
                                               pend_reg.rstart, pend_reg.rend,
                                               1'b0, 1'b0, 1'b0};
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = '{idx_reg[TX_AW-1:0], rg_t, rg_s, rg_e};
                        hits_next       = hits_reg + 1'b1;
                        j_next          = j_reg + 1'b1;
                        state_next      = S_REG_ISSUE;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_REG_ISSUE;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    if (!over_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = '{pos_reg, '0, '0, '0, '0, 1'b1, 1'b0, 1'b1};
                    end
                    else if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = '{pos_reg, pend_reg.tx, pend_reg.rtype,
                                          pend_reg.rstart, pend_reg.rend,
                                          1'b0, trunc_reg, 1'b1};
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        first_reg <= first_next;
        cnt_reg   <= cnt_next;
        j_reg     <= j_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tx_count_reg   <= '0;
            rg_count_reg   <= '0;
            wbase_reg      <= '0;
            cur_cnt_reg    <= '0;
            idx_reg        <= '0;
            hits_reg       <= '0;
            over_reg       <= 1'b0;
            trunc_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tx_count_reg   <= tx_count_next;
            rg_count_reg   <= rg_count_next;
            wbase_reg      <= wbase_next;
            cur_cnt_reg    <= cur_cnt_next;
            idx_reg        <= idx_next;
            hits_reg       <= hits_next;
            over_reg       <= over_next;
            trunc_reg      <= trunc_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.echo_position  = out_reg.echo_position;
    assign rsp.hit_transcript = out_reg.hit_transcript;
    assign rsp.hit_type       = out_reg.hit_type;
    assign rsp.hit_start      = out_reg.hit_start;
    assign rsp.hit_end        = out_reg.hit_end;
    assign rsp.intergenic     = out_reg.intergenic;
    assign rsp.truncated      = out_reg.truncated;
    assign rsp.last           = out_reg.last;
endmodule
